@@ hdl/cdr_pkg.sv @@
// Shared types and constants for the character display refresh unit.
package cdr_pkg;

    // Input action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    // Result kinds
    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_CHAR = 1'b1;

    localparam logic [7:0] SPACE_CHAR   = 8'h20;
    localparam logic [7:0] NUL_CHAR     = 8'h00;
    localparam logic [7:0] PERIOD_RESET = 8'd10;

    // Commands handed from the front to the back
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_CLEAR,
        OP_SCAN
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       row;
        logic [3:0] col;
        logic [7:0] chr;
    } t_cmd;

    // One result beat
    typedef struct packed {
        logic       kind;
        logic       row;
        logic [3:0] col;
        logic [7:0] chr;
        logic       last;
    } t_res;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_MOVE,
        ST_CHAR
    } t_bstate;

endpackage

@@ hdl/cdr_front.sv @@
// Front end: accepts items, runs the tick counter, queues commands for the back end.
module cdr_front #(
    parameter int ROWS    = 2,
    parameter int COLUMNS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [1:0]    i_action,
    input  logic          i_row,
    input  logic [3:0]    i_column,
    input  logic [7:0]    i_char_code,
    input  logic          i_out_en,
    input  logic [7:0]    i_period,
    output logic          o_cmd_vld,
    output cdr_pkg::t_cmd o_cmd,
    input  logic          i_cmd_rdy
);

    cdr_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic [7:0]    r_tick;

    logic          w_acc;
    logic          w_enq;
    logic          w_deq;
    logic [7:0]    w_tick_dec;
    cdr_pkg::t_cmd w_cmd;

    assign o_full     = (r_cnt == 2'd2);
    assign w_acc      = i_push && !o_full;
    assign w_tick_dec = r_tick - 8'd1;
    assign o_cmd_vld  = (r_cnt != 2'd0);
    assign o_cmd      = r_q[r_rp];
    assign w_deq      = o_cmd_vld && i_cmd_rdy;

    // Classify: only in-frame writes, clears and expiring ticks with output on go to the back
    always_comb begin
        w_enq     = 1'b0;
        w_cmd.op  = cdr_pkg::OP_WRITE;
        w_cmd.row = i_row;
        w_cmd.col = i_column;
        w_cmd.chr = i_char_code;
        case (i_action)
            cdr_pkg::ACT_WRITE: begin
                w_enq = (int'(i_row) < ROWS) && (int'(i_column) < COLUMNS);
            end
            cdr_pkg::ACT_CLEAR: begin
                w_enq    = 1'b1;
                w_cmd.op = cdr_pkg::OP_CLEAR;
            end
            cdr_pkg::ACT_TICK: begin
                w_enq    = (w_tick_dec == 8'd0) && i_out_en;
                w_cmd.op = cdr_pkg::OP_SCAN;
            end
            default: begin
                w_enq = 1'b0;
            end
        endcase
    end

    // Tick counter and command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= 2'd0;
            r_tick <= cdr_pkg::PERIOD_RESET;
        end else begin
            if (w_acc && i_action == cdr_pkg::ACT_TICK) begin
                r_tick <= (w_tick_dec == 8'd0) ? i_period : w_tick_dec;
            end
            if (w_acc && w_enq) begin
                r_q[r_wp] <= w_cmd;
                r_wp      <= ~r_wp;
            end
            if (w_deq) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_acc && w_enq) - 2'(w_deq);
        end
    end

endmodule

@@ hdl/cdr_back.sv @@
// Back end: frame and shadow stores, refresh scan sequencer and result register.
module cdr_back #(
    parameter int ROWS    = 2,
    parameter int COLUMNS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_vld,
    input  cdr_pkg::t_cmd i_cmd,
    output logic          o_cmd_rdy,
    output logic          o_res_vld,
    output cdr_pkg::t_res o_res,
    input  logic          i_pop
);

    logic [7:0]       r_frame  [ROWS][COLUMNS];
    logic [7:0]       r_shadow [ROWS][COLUMNS];
    cdr_pkg::t_bstate r_state;
    cdr_pkg::t_bstate n_state;
    logic             r_row;
    logic [3:0]       r_col;
    logic             r_ended;
    logic [ROWS-1:0]  r_any;
    logic [3:0]       r_first [ROWS];
    logic [3:0]       r_lastc [ROWS];
    cdr_pkg::t_res    r_out;
    logic             r_out_vld;

    logic [7:0]       w_cell;
    logic             w_end;
    logic [7:0]       w_eff;
    logic             w_diff;
    logic             w_row_end;
    logic             w_last_row;
    logic             w_last_col;
    logic             w_later;
    logic             w_out_free;
    logic             w_emit;
    cdr_pkg::t_res    w_res;

    assign o_res_vld = r_out_vld;
    assign o_res     = r_out;

    // Compare datapath: one cell per cycle, a NUL blanks the rest of its row
    assign w_cell     = r_frame[r_row][r_col];
    assign w_end      = r_ended || (w_cell == cdr_pkg::NUL_CHAR);
    assign w_eff      = w_end ? cdr_pkg::SPACE_CHAR : w_cell;
    assign w_diff     = (w_eff != r_shadow[r_row][r_col]);
    assign w_row_end  = (r_col == 4'(COLUMNS - 1));
    assign w_last_row = (r_row == 1'(ROWS - 1));
    assign w_last_col = (r_col == r_lastc[r_row]);
    assign w_out_free = !r_out_vld || i_pop;

    // Any changed row after the current one
    always_comb begin
        w_later = 1'b0;
        for (int j = 0; j < ROWS; j++) begin
            if (j > int'(r_row) && r_any[j]) begin
                w_later = 1'b1;
            end
        end
    end

    // Sequencer outputs
    always_comb begin
        o_cmd_rdy = 1'b0;
        w_emit    = 1'b0;
        w_res     = '0;
        case (r_state)
            cdr_pkg::ST_IDLE: begin
                o_cmd_rdy = 1'b1;
            end
            cdr_pkg::ST_MOVE: begin
                if (r_any[r_row] && w_out_free) begin
                    w_emit     = 1'b1;
                    w_res.kind = cdr_pkg::KIND_MOVE;
                    w_res.row  = r_row;
                    w_res.col  = r_first[r_row];
                    w_res.chr  = cdr_pkg::NUL_CHAR;
                    w_res.last = 1'b0;
                end
            end
            cdr_pkg::ST_CHAR: begin
                if (w_out_free) begin
                    w_emit     = 1'b1;
                    w_res.kind = cdr_pkg::KIND_CHAR;
                    w_res.row  = r_row;
                    w_res.col  = r_col;
                    w_res.chr  = r_shadow[r_row][r_col];
                    w_res.last = w_last_col && !w_later;
                end
            end
            default: begin
                o_cmd_rdy = 1'b0;
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdr_pkg::ST_IDLE: begin
                if (i_cmd_vld && i_cmd.op == cdr_pkg::OP_SCAN) begin
                    n_state = cdr_pkg::ST_CMP;
                end
            end
            cdr_pkg::ST_CMP: begin
                if (w_row_end && w_last_row) begin
                    n_state = cdr_pkg::ST_MOVE;
                end
            end
            cdr_pkg::ST_MOVE: begin
                if (!r_any[r_row]) begin
                    if (w_last_row) begin
                        n_state = cdr_pkg::ST_IDLE;
                    end
                end else if (w_emit) begin
                    n_state = cdr_pkg::ST_CHAR;
                end
            end
            cdr_pkg::ST_CHAR: begin
                if (w_emit && w_last_col) begin
                    n_state = w_last_row ? cdr_pkg::ST_IDLE : cdr_pkg::ST_MOVE;
                end
            end
            default: begin
                n_state = cdr_pkg::ST_IDLE;
            end
        endcase
    end

    // Stores, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cdr_pkg::ST_IDLE;
            r_out_vld <= 1'b0;
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLUMNS; c++) begin
                    r_frame[r][c]  <= cdr_pkg::SPACE_CHAR;
                    r_shadow[r][c] <= cdr_pkg::SPACE_CHAR;
                end
            end
        end else begin
            r_state <= n_state;

            if (w_emit) begin
                r_out     <= w_res;
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                cdr_pkg::ST_IDLE: begin
                    if (i_cmd_vld) begin
                        case (i_cmd.op)
                            cdr_pkg::OP_WRITE: begin
                                r_frame[i_cmd.row][i_cmd.col] <= i_cmd.chr;
                            end
                            cdr_pkg::OP_CLEAR: begin
                                for (int r = 0; r < ROWS; r++) begin
                                    for (int c = 0; c < COLUMNS; c++) begin
                                        r_frame[r][c] <= cdr_pkg::SPACE_CHAR;
                                    end
                                end
                            end
                            cdr_pkg::OP_SCAN: begin
                                r_row   <= 1'b0;
                                r_col   <= 4'd0;
                                r_ended <= 1'b0;
                                r_any   <= '0;
                            end
                            default: begin
                                r_ended <= 1'b0;
                            end
                        endcase
                    end
                end
                cdr_pkg::ST_CMP: begin
                    r_shadow[r_row][r_col] <= w_eff;
                    if (w_diff) begin
                        if (!r_any[r_row]) begin
                            r_first[r_row] <= r_col;
                        end
                        r_any[r_row]   <= 1'b1;
                        r_lastc[r_row] <= r_col;
                    end
                    if (w_row_end) begin
                        r_col   <= 4'd0;
                        r_ended <= 1'b0;
                        r_row   <= w_last_row ? 1'b0 : r_row + 1'b1;
                    end else begin
                        r_col   <= r_col + 4'd1;
                        r_ended <= w_end;
                    end
                end
                cdr_pkg::ST_MOVE: begin
                    if (!r_any[r_row]) begin
                        if (!w_last_row) begin
                            r_row <= r_row + 1'b1;
                        end
                    end else if (w_emit) begin
                        r_col <= r_first[r_row];
                    end
                end
                cdr_pkg::ST_CHAR: begin
                    if (w_emit) begin
                        if (w_last_col) begin
                            if (!w_last_row) begin
                                r_row <= r_row + 1'b1;
                            end
                        end else begin
                            r_col <= r_col + 4'd1;
                        end
                    end
                end
                default: begin
                    r_ended <= 1'b0;
                end
            endcase
        end
    end

endmodule

@@ hdl/char_display_diff_refresh_unit.sv @@
// Top level of the character display refresh unit with change detection.
// A write or clear beat waits in the front queue until the back end, when idle, applies it.
// A scan tick compares every stored cell in turn (ROWS*COLUMNS, 32 by default), then emits
// the result beats, stepping past unchanged rows; the back end is busy meanwhile.
// Throughput: one scan at a time; up to two queued commands let pushes continue during it.
// Reset is synchronous: both stores read as spaces, period 10, output enabled, queues empty.
module char_display_diff_refresh_unit #(
    parameter int ROWS    = 2,
    parameter int COLUMNS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_action,
    input  logic       i_row,
    input  logic [3:0] i_column,
    input  logic [7:0] i_char_code,
    output logic       empty,
    input  logic       pop,
    output logic       o_kind,
    output logic       o_out_row,
    output logic [3:0] o_out_column,
    output logic [7:0] o_out_char,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic          r_out_en;
    logic [7:0]    r_period;

    logic          w_cmd_vld;
    logic          w_cmd_rdy;
    cdr_pkg::t_cmd w_cmd;
    logic          w_res_vld;
    cdr_pkg::t_res w_res;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_en <= 1'b1;
            r_period <= cdr_pkg::PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cdr_pkg::REG_ENABLE: r_out_en <= i_cfg_data[0];
                cdr_pkg::REG_PERIOD: r_period <= i_cfg_data;
                default:             r_period <= r_period;
            endcase
        end
    end

    cdr_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_action    (i_action),
        .i_row       (i_row),
        .i_column    (i_column),
        .i_char_code (i_char_code),
        .i_out_en    (r_out_en),
        .i_period    (r_period),
        .o_cmd_vld   (w_cmd_vld),
        .o_cmd       (w_cmd),
        .i_cmd_rdy   (w_cmd_rdy)
    );

    cdr_back #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (w_cmd_vld),
        .i_cmd     (w_cmd),
        .o_cmd_rdy (w_cmd_rdy),
        .o_res_vld (w_res_vld),
        .o_res     (w_res),
        .i_pop     (pop)
    );

    // Result beat onto the ports
    assign empty        = !w_res_vld;
    assign o_kind       = w_res.kind;
    assign o_out_row    = w_res.row;
    assign o_out_column = w_res.col;
    assign o_out_char   = w_res.chr;
    assign o_last       = w_res.last;

`ifndef ASSERT_OFF
    // A cursor move never carries a character and never closes a scan
    a_move_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == cdr_pkg::KIND_MOVE) |-> (o_out_char == 8'h00 && !o_last))
        else $error("cursor move beat with character or last marker");

    // A command the back end has not taken stays offered
    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd_vld && !w_cmd_rdy) |=> w_cmd_vld)
        else $error("queued command dropped before the back end took it");

    // A full front queue always offers a command to the back end
    a_full_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_cmd_vld)
        else $error("front queue full with no command offered");
`endif

endmodule

@@ tb/sv/display_refresh_checker.sv @@
`timescale 1ns / 100ps
// Checker for the display refresh unit: predicts every result beat and compares it.
module display_refresh_checker #(
    parameter int ROWS    = 2,
    parameter int COLUMNS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic       i_full,
    input  logic [1:0] i_action,
    input  logic       i_row,
    input  logic [3:0] i_column,
    input  logic [7:0] i_char_code,
    input  logic       i_empty,
    input  logic       i_pop,
    input  logic       i_kind,
    input  logic       i_out_row,
    input  logic [3:0] i_out_column,
    input  logic [7:0] i_out_char,
    input  logic       i_last,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending
);

    localparam int CELLS = ROWS * COLUMNS;

    // Predicted copy of the block state
    logic [7:0] frame_mem [CELLS];
    logic [7:0] shown_mem [CELLS];
    logic [7:0] ticks_left;
    logic [7:0] period_reg;
    logic       show_on;

    // Display beats still owed by the block, oldest first
    cdr_pkg::t_res display_beats_q[$];

    int mismatch_count = 0;
    int pending_count  = 0;
    int beat_no        = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = pending_count;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    always @(posedge i_clk) begin
        cdr_pkg::t_res want;
        cdr_pkg::t_res beat;
        cdr_pkg::t_res scan_q[$];
        logic [7:0]    cur_chr;
        logic          ended;
        logic          changed;
        int            first_col;
        int            last_col;
        int            idx;

        if (!i_rst_n) begin
            for (int k = 0; k < CELLS; k++) begin
                frame_mem[k] = cdr_pkg::SPACE_CHAR;
                shown_mem[k] = cdr_pkg::SPACE_CHAR;
            end
            ticks_left = cdr_pkg::PERIOD_RESET;
            period_reg = cdr_pkg::PERIOD_RESET;
            show_on    = 1'b1;
            display_beats_q.delete();
        end else begin
            // register write beat
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    cdr_pkg::REG_ENABLE: show_on    = i_cfg_data[0];
                    cdr_pkg::REG_PERIOD: period_reg = i_cfg_data;
                    default: ;
                endcase
            end

            // result beat: compare with the oldest expectation
            if (i_pop && !i_empty) begin
                beat_no++;
                if (display_beats_q.size() == 0) begin
                    report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_no));
                end else begin
                    want = display_beats_q.pop_front();
                    if (i_kind != want.kind)
                        report_mismatch($sformatf("beat %0d kind %0d, want %0d",
                                                  beat_no, i_kind, want.kind));
                    if (i_out_row != want.row)
                        report_mismatch($sformatf("beat %0d row %0d, want %0d",
                                                  beat_no, i_out_row, want.row));
                    if (i_out_column != want.col)
                        report_mismatch($sformatf("beat %0d column %0d, want %0d",
                                                  beat_no, i_out_column, want.col));
                    if (i_out_char != want.chr)
                        report_mismatch($sformatf("beat %0d char %02h, want %02h",
                                                  beat_no, i_out_char, want.chr));
                    if (i_last != want.last)
                        report_mismatch($sformatf("beat %0d last %0d, want %0d",
                                                  beat_no, i_last, want.last));
                end
            end

            // input beat: update the frame, maybe run a refresh scan
            if (i_push && !i_full) begin
                case (i_action)
                    cdr_pkg::ACT_WRITE: frame_mem[i_row * COLUMNS + i_column] = i_char_code;
                    cdr_pkg::ACT_CLEAR: begin
                        for (int k = 0; k < CELLS; k++) frame_mem[k] = cdr_pkg::SPACE_CHAR;
                    end
                    cdr_pkg::ACT_TICK: begin
                        ticks_left = ticks_left - 8'd1;
                        if (ticks_left == 8'd0) begin
                            if (show_on) begin
                                scan_q.delete();
                                for (int r = 0; r < ROWS; r++) begin
                                    ended     = 1'b0;
                                    changed   = 1'b0;
                                    first_col = 0;
                                    last_col  = 0;
                                    for (int c = 0; c < COLUMNS; c++) begin
                                        idx     = r * COLUMNS + c;
                                        cur_chr = frame_mem[idx];
                                        // a NUL blanks the rest of the row
                                        if (cur_chr == cdr_pkg::NUL_CHAR) ended = 1'b1;
                                        if (ended) cur_chr = cdr_pkg::SPACE_CHAR;
                                        if (cur_chr != shown_mem[idx]) begin
                                            if (!changed) first_col = c;
                                            changed  = 1'b1;
                                            last_col = c;
                                        end
                                        shown_mem[idx] = cur_chr;
                                    end
                                    if (changed) begin
                                        beat.kind = cdr_pkg::KIND_MOVE;
                                        beat.row  = r[0];
                                        beat.col  = first_col[3:0];
                                        beat.chr  = cdr_pkg::NUL_CHAR;
                                        beat.last = 1'b0;
                                        scan_q.push_back(beat);
                                        for (int c = first_col; c <= last_col; c++) begin
                                            beat.kind = cdr_pkg::KIND_CHAR;
                                            beat.col  = c[3:0];
                                            beat.chr  = shown_mem[r * COLUMNS + c];
                                            scan_q.push_back(beat);
                                        end
                                    end
                                end
                                if (scan_q.size() > 0) begin
                                    beat      = scan_q.pop_back();
                                    beat.last = 1'b1;
                                    scan_q.push_back(beat);
                                end
                                foreach (scan_q[k]) display_beats_q.push_back(scan_q[k]);
                            end
                            ticks_left = period_reg;
                        end
                    end
                    default: ;
                endcase
            end
        end
        pending_count = display_beats_q.size();
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives the display refresh unit and gives the verdict.
module tb;

    // action code the block leaves unused
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       push        = 1'b0;
    logic [1:0] i_action    = cdr_pkg::ACT_TICK;
    logic       i_row       = 1'b0;
    logic [3:0] i_column    = 4'd0;
    logic [7:0] i_char_code = 8'd0;
    logic       pop         = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_index = cdr_pkg::REG_ENABLE;
    logic [7:0] i_cfg_data  = 8'd0;
    logic       full;
    logic       empty;
    logic       o_kind;
    logic       o_out_row;
    logic [3:0] o_out_column;
    logic [7:0] o_out_char;
    logic       o_last;
    logic       o_cfg_ready;

    int   send_idle_pct = 22;
    int   take_idle_pct = 74;
    logic hold_on       = 1'b0;
    int   mismatches;
    int   beats_pending;
    event hold_trigger;

    char_display_diff_refresh_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_char_code  (i_char_code),
        .empty        (empty),
        .pop          (pop),
        .o_kind       (o_kind),
        .o_out_row    (o_out_row),
        .o_out_column (o_out_column),
        .o_out_char   (o_out_char),
        .o_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    display_refresh_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_action     (i_action),
        .i_row        (i_row),
        .i_column     (i_column),
        .i_char_code  (i_char_code),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_kind       (o_kind),
        .i_out_row    (o_out_row),
        .i_out_column (o_out_column),
        .i_out_char   (o_out_char),
        .i_last       (o_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (mismatches),
        .o_pending    (beats_pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus one long hold-off
    always @(posedge i_clk) begin
        pop <= !hold_on && ($urandom_range(99) >= take_idle_pct);
    end

    initial begin
        @(hold_trigger);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Offer one input beat, with random gaps before it; returns once accepted
    task automatic send_item(input logic [1:0] act, input logic row, input logic [3:0] col,
                             input logic [7:0] chr);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_action    <= act;
        i_row       <= row;
        i_column    <= col;
        i_char_code <= chr;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Mostly printable text, with NULs, spaces and arbitrary bytes mixed in
    function automatic logic [7:0] pick_char();
        int p;
        p = $urandom_range(99);
        if (p < 8) return cdr_pkg::NUL_CHAR;
        if (p < 14) return cdr_pkg::SPACE_CHAR;
        if (p < 24) return 8'($urandom_range(255));
        return 8'($urandom_range(8'h7E, 8'h21));
    endfunction

    task automatic send_random_item();
        int         pick;
        logic [1:0] act;
        logic       row;
        logic [3:0] col;
        pick = $urandom_range(99);
        if (pick < 48) act = cdr_pkg::ACT_WRITE;
        else if (pick < 53) act = cdr_pkg::ACT_CLEAR;
        else if (pick < 56) act = ACT_NONE;
        else act = cdr_pkg::ACT_TICK;
        row = 1'($urandom_range(1));
        col = 4'($urandom_range(15));
        send_item(act, row, col, pick_char());
    endtask

    // Writes both registers; the block must be idle
    task automatic set_mode(input logic enable, input logic [7:0] period);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= cdr_pkg::REG_ENABLE;
        i_cfg_data  <= {7'($urandom_range(127)), enable};
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= cdr_pkg::REG_PERIOD;
        i_cfg_data  <= period;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for every owed beat, then let a scan with no output finish
    task automatic wait_drained();
        push <= 1'b0;
        @(negedge i_clk);
        while (beats_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: counter starts at 10, then every tick scans
        set_mode(1'b1, 8'd1);
        send_item(cdr_pkg::ACT_WRITE, 1'b0, 4'd0, 8'h41);
        send_item(cdr_pkg::ACT_WRITE, 1'b0, 4'd15, 8'hFF);
        send_item(cdr_pkg::ACT_WRITE, 1'b1, 4'd5, 8'h5A);
        send_item(cdr_pkg::ACT_WRITE, 1'b1, 4'd6, cdr_pkg::NUL_CHAR); // hides the rest of row 1
        send_item(cdr_pkg::ACT_WRITE, 1'b1, 4'd10, 8'h51);
        send_item(ACT_NONE, 1'b1, 4'd15, 8'hFF);
        repeat (10) send_item(cdr_pkg::ACT_TICK, 1'b0, 4'd0, 8'd0);
        send_item(cdr_pkg::ACT_WRITE, 1'b1, 4'd6, 8'h42);  // uncovers the hidden text
        send_item(cdr_pkg::ACT_TICK, 1'b1, 4'd15, 8'hFF);
        send_item(cdr_pkg::ACT_TICK, 1'b0, 4'd0, 8'd0);    // nothing changed
        send_item(cdr_pkg::ACT_CLEAR, 1'b0, 4'd0, 8'd0);
        send_item(cdr_pkg::ACT_TICK, 1'b0, 4'd0, 8'd0);
        send_item(cdr_pkg::ACT_WRITE, 1'b0, 4'd7, 8'h78);
        send_item(cdr_pkg::ACT_TICK, 1'b0, 4'd0, 8'd0);    // single changed column
        send_item(cdr_pkg::ACT_WRITE, 1'b0, 4'd7, cdr_pkg::NUL_CHAR);
        send_item(cdr_pkg::ACT_TICK, 1'b0, 4'd0, 8'd0);
        wait_drained();

        // Random text with slow result side
        set_mode(1'b1, 8'd3);
        repeat (70) send_random_item();
        wait_drained();

        // Output disabled: counter runs, nothing comes out
        set_mode(1'b0, 8'd2);
        repeat (24) send_random_item();
        wait_drained();

        // Slow input side
        send_idle_pct <= 74;
        take_idle_pct <= 22;
        set_mode(1'b1, 8'd2);
        repeat (70) send_random_item();
        wait_drained();

        // No idling; result side held off long enough for the input to stall
        send_idle_pct <= 0;
        take_idle_pct <= 0;
        set_mode(1'b1, 8'd1);
        -> hold_trigger;
        repeat (20) begin
            send_item(cdr_pkg::ACT_WRITE, 1'($urandom_range(1)), 4'($urandom_range(15)),
                      8'($urandom_range(8'h7E, 8'h21)));
            send_item(cdr_pkg::ACT_TICK, 1'b0, 4'd0, 8'd0);
        end
        repeat (30) send_random_item();
        wait_drained();

        // Period of zero: counter sits at 1, so the first tick scans and
        // reloads zero; the next tick wraps it to 255 and no scan follows
        set_mode(1'b1, 8'd0);
        repeat (60) begin
            if ($urandom_range(9) == 0) begin
                send_item(cdr_pkg::ACT_WRITE, 1'($urandom_range(1)), 4'($urandom_range(15)),
                          pick_char());
            end
            send_item(cdr_pkg::ACT_TICK, 1'($urandom_range(1)), 4'($urandom_range(15)),
                      8'($urandom_range(255)));
        end
        wait_drained();

        // Longest period
        set_mode(1'b1, 8'd255);
        repeat (6) send_random_item();
        wait_drained();

        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/cdr_pkg.sv
hdl/cdr_front.sv
hdl/cdr_back.sv
hdl/char_display_diff_refresh_unit.sv
tb/sv/display_refresh_checker.sv
tb/sv/tb.sv
